### design/rsd_pkg.sv
// ----------------------------------------------------------------------------
// rsd_pkg
// Shared constants, types and the signature hash for the RRIP/SHiP/DIP
// replacement unit.
// ----------------------------------------------------------------------------
package rsd_pkg;

	localparam int NUM_SETS    = 2048;
	localparam int SET_W       = $clog2(NUM_SETS);
	localparam int NUM_WAYS    = 16;
	localparam int WAY_W       = $clog2(NUM_WAYS);
	localparam int SIG_ENTRIES = 1024;
	localparam int SIG_W       = $clog2(SIG_ENTRIES);
	localparam int DUEL_PERIOD = 64;
	localparam int DUEL_W      = $clog2(DUEL_PERIOD);
	localparam int PC_W        = 64;
	localparam int HASH_SH_A   = 13;
	localparam int HASH_SH_B   = 23;
	localparam int SEL_W       = 10;

	localparam logic [1:0]       RRPV_DISTANT = 2'd3;
	localparam logic [1:0]       RRPV_NEAR    = 2'd0;
	localparam logic [1:0]       CTR_TOP      = 2'd3;
	localparam logic [1:0]       CTR_ZERO     = 2'd0;
	localparam logic [1:0]       SIG_RESET    = 2'd1;
	localparam logic [SEL_W-1:0] SEL_TOP      = 10'd1023;
	localparam logic [SEL_W-1:0] SEL_MID      = 10'd511;
	localparam logic [SEL_W-1:0] SEL_ZERO     = 10'd0;

	typedef enum logic {
		OP_VICTIM = 1'b0,
		OP_UPDATE = 1'b1
	} op_t;

	// one 2-bit field per way
	typedef logic [NUM_WAYS-1:0][1:0] row_t;

	typedef struct packed {
		logic [WAY_W-1:0] way;
		row_t             aged;
	} victim_t;

	// Signature index: low bits of pc ^ pc>>13 ^ pc>>23
	function automatic logic [SIG_W-1:0] sig_hash(input logic [PC_W-1:0] pc);
		logic [PC_W-1:0] h;
		h = pc ^ (pc >> HASH_SH_A) ^ (pc >> HASH_SH_B);
		return h[SIG_W-1:0];
	endfunction

endpackage

### design/rsd_victim_pick.sv
// ----------------------------------------------------------------------------
// rsd_victim_pick
// Ages one set row so its oldest lines reach the distant value and picks the
// first dead distant line, else the first distant line.
// ----------------------------------------------------------------------------
module rsd_victim_pick (
	input  rsd_pkg::row_t    rr_row,
	input  rsd_pkg::row_t    dc_row,
	output rsd_pkg::victim_t pick
);

	logic       has3, has2, has1;
	logic [1:0] top;
	logic [1:0] age;
	logic [rsd_pkg::WAY_W-1:0] first_dead, first_dist;
	logic       dead_found;

	always_comb begin
		has3 = 1'b0;
		has2 = 1'b0;
		has1 = 1'b0;
		for (int w = 0; w < rsd_pkg::NUM_WAYS; w++) begin
			has3 = has3 | (rr_row[w] == 2'd3);
			has2 = has2 | (rr_row[w] == 2'd2);
			has1 = has1 | (rr_row[w] == 2'd1);
		end
		top = has3 ? 2'd3 : (has2 ? 2'd2 : (has1 ? 2'd1 : 2'd0));
		age = rsd_pkg::RRPV_DISTANT - top;
	end

	always_comb begin
		first_dead = '0;
		first_dist = '0;
		dead_found = 1'b0;
		// scan from the top so the lowest matching way wins
		for (int w = rsd_pkg::NUM_WAYS - 1; w >= 0; w--) begin
			if (rr_row[w] == top) begin
				first_dist = w[rsd_pkg::WAY_W-1:0];
				if (dc_row[w] == rsd_pkg::CTR_ZERO) begin
					first_dead = w[rsd_pkg::WAY_W-1:0];
					dead_found = 1'b1;
				end
			end
		end
		for (int w = 0; w < rsd_pkg::NUM_WAYS; w++) begin
			pick.aged[w] = rr_row[w] + age;
		end
		pick.way = dead_found ? first_dead : first_dist;
	end

endmodule

### design/rrip_ship_dip_replacement_unit.sv
// ----------------------------------------------------------------------------
// rrip_ship_dip_replacement_unit
// LLC replacement policy: SRRIP re-reference values with per-line dead
// counters, PC-signature confidence counters and a set-dueling selector.
// ----------------------------------------------------------------------------
//
//  channel | valid    | stall     | payload
//  --------+----------+-----------+-------------------------------------------
//  request | in_valid | in_stall  | operation, set_index, way, pc, hit
//  result  | out_valid| out_stall | victim_way (victim queries only)
//
// For each request the set row and the signature counter are read from
// single-port synchronous memories in the accept cycle, then the row is
// modified and written back in the execute state. That read-modify-write
// loop means a new request is taken only once the last one is written back.
// After reset a clearing pass sweeps all 2048 sets of the row memories (and
// the signature memory) before the first request is taken.
// A victim result waits in an output register; a query that finds it still
// full holds in the execute state until it drains, updates never wait.
// ----------------------------------------------------------------------------
module rrip_ship_dip_replacement_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              operation,
	input  logic [10:0]                       set_index,
	input  logic [3:0]                        way,
	input  logic [63:0]                       pc,
	input  logic                              hit,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [3:0]                        victim_way
);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;
	logic [rsd_pkg::SET_W-1:0] clr_q;
	logic [rsd_pkg::SEL_W-1:0] sel_q;
	logic                      out_valid_q;
	logic [rsd_pkg::WAY_W-1:0] victim_q;

	// request captured at accept
	logic                      op_s1;
	logic [rsd_pkg::SET_W-1:0] set_s1;
	logic [rsd_pkg::WAY_W-1:0] way_s1;
	logic [rsd_pkg::SIG_W-1:0] sig_s1;
	logic                      hit_s1;

	// memories and their registered read data
	rsd_pkg::row_t rr_mem [rsd_pkg::NUM_SETS];
	rsd_pkg::row_t dc_mem [rsd_pkg::NUM_SETS];
	logic [1:0]    sig_mem [rsd_pkg::SIG_ENTRIES];
	rsd_pkg::row_t rr_rd_q, dc_rd_q;
	logic [1:0]    sig_rd_q;

	logic accept, proceed;
	logic [rsd_pkg::SIG_W-1:0] sig_in;

	// write ports
	logic                      row_we, dc_we, sig_we;
	logic [rsd_pkg::SET_W-1:0] row_waddr;
	logic [rsd_pkg::SIG_W-1:0] sig_waddr;
	rsd_pkg::row_t             rr_wdata, dc_wdata;
	logic [1:0]                sig_wdata;

	// update arithmetic
	logic [rsd_pkg::SEL_W-1:0] sel_next;
	logic [1:0]                sig_inc, sig_dec;
	logic [1:0]                new_rr, new_dc;

	rsd_pkg::victim_t pick;

	rsd_victim_pick u_pick (
		.rr_row (rr_rd_q),
		.dc_row (dc_rd_q),
		.pick   (pick)
	);

	assign in_stall   = (state_q != ST_IDLE);
	assign accept     = in_valid && (state_q == ST_IDLE);
	assign sig_in     = rsd_pkg::sig_hash(pc);
	assign out_valid  = out_valid_q;
	assign victim_way = victim_q;

	// a query may only finish when the result register is free or draining
	assign proceed = (state_q == ST_EXEC) &&
		((op_s1 == rsd_pkg::OP_UPDATE) || !out_valid_q || !out_stall);

	// Update arithmetic: dueling selector, signature counter, placement
	always_comb begin
		// lower half of the duel period marks a BIP leader: raise on miss
		if (set_s1[rsd_pkg::DUEL_W-1] == 1'b0) begin
			sel_next = (sel_q == rsd_pkg::SEL_TOP) ? sel_q : sel_q + rsd_pkg::SEL_W'(1);
		end else begin
			sel_next = (sel_q == rsd_pkg::SEL_ZERO) ? sel_q : sel_q - rsd_pkg::SEL_W'(1);
		end
		sig_inc = (sig_rd_q == rsd_pkg::CTR_TOP) ? sig_rd_q : sig_rd_q + 2'd1;
		sig_dec = (sig_rd_q == rsd_pkg::CTR_ZERO) ? sig_rd_q : sig_rd_q - 2'd1;

		if (hit_s1) begin
			new_rr = rsd_pkg::RRPV_NEAR;
			new_dc = rsd_pkg::CTR_TOP;
		end else if (sig_dec == rsd_pkg::CTR_ZERO) begin
			new_rr = rsd_pkg::RRPV_DISTANT;
			new_dc = rsd_pkg::CTR_ZERO;
		end else if (sig_dec == rsd_pkg::CTR_TOP) begin
			new_rr = rsd_pkg::RRPV_NEAR;
			new_dc = rsd_pkg::CTR_TOP;
		end else if (sel_next >= rsd_pkg::SEL_MID) begin
			new_rr = rsd_pkg::RRPV_NEAR;
			new_dc = rsd_pkg::CTR_TOP;
		end else begin
			new_rr = rsd_pkg::RRPV_DISTANT;
			new_dc = rsd_pkg::CTR_TOP;
		end
	end

	// Write-port steering: clearing sweep, victim ageing or line placement
	always_comb begin
		row_we    = 1'b0;
		dc_we     = 1'b0;
		sig_we    = 1'b0;
		row_waddr = set_s1;
		sig_waddr = sig_s1;
		rr_wdata  = rr_rd_q;
		dc_wdata  = dc_rd_q;
		sig_wdata = hit_s1 ? sig_inc : sig_dec;
		case (state_q)
			ST_CLEAR: begin
				row_we    = 1'b1;
				dc_we     = 1'b1;
				row_waddr = clr_q;
				// the signature table is shorter: cover it in the first part
				sig_we    = (clr_q[rsd_pkg::SET_W-1:rsd_pkg::SIG_W] == '0);
				sig_waddr = clr_q[rsd_pkg::SIG_W-1:0];
				sig_wdata = rsd_pkg::SIG_RESET;
				for (int w = 0; w < rsd_pkg::NUM_WAYS; w++) begin
					rr_wdata[w] = rsd_pkg::RRPV_DISTANT;
					dc_wdata[w] = rsd_pkg::CTR_ZERO;
				end
			end
			ST_EXEC: begin
				if (proceed) begin
					row_we = 1'b1;
					if (op_s1 == rsd_pkg::OP_VICTIM) begin
						rr_wdata = pick.aged;
					end else begin
						dc_we  = 1'b1;
						sig_we = 1'b1;
						rr_wdata[way_s1] = new_rr;
						dc_wdata[way_s1] = new_dc;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Row memories: single port, registered read
	always_ff @(posedge clk) begin
		if (row_we) begin
			rr_mem[row_waddr] <= rr_wdata;
		end
		if (dc_we) begin
			dc_mem[row_waddr] <= dc_wdata;
		end
		if (accept) begin
			rr_rd_q <= rr_mem[set_index];
			dc_rd_q <= dc_mem[set_index];
		end
	end

	// Signature counter memory
	always_ff @(posedge clk) begin
		if (sig_we) begin
			sig_mem[sig_waddr] <= sig_wdata;
		end
		if (accept) begin
			sig_rd_q <= sig_mem[sig_in];
		end
	end

	// Request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1  <= operation;
			set_s1 <= set_index;
			way_s1 <= way;
			sig_s1 <= sig_in;
			hit_s1 <= hit;
		end
	end

	// Sequencer, selector and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			sel_q       <= rsd_pkg::SEL_MID;
			out_valid_q <= 1'b0;
			victim_q    <= '0;
		end else begin
			// drop the result once taken; a new one below overrides
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + rsd_pkg::SET_W'(1);
					if (clr_q == rsd_pkg::SET_W'(rsd_pkg::NUM_SETS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (proceed) begin
						state_q <= ST_IDLE;
						if (op_s1 == rsd_pkg::OP_VICTIM) begin
							out_valid_q <= 1'b1;
							victim_q    <= pick.way;
						end else if (!hit_s1) begin
							sel_q <= sel_next;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### verif/rrip_ship_dip_replacement_unit_test.sv
// ----------------------------------------------------------------------------
// rrip_ship_dip_replacement_unit_test
// Self-checking bench for the RRIP/SHiP/DIP replacement unit. A behavioural
// copy of the per-line re-reference and dead counters, the signature table
// and the dueling selector predicts every victim way. The stimulus starts with
// hand-picked requests, then moves to structured random traffic under rotating
// sender idling and result back-pressure.
// ----------------------------------------------------------------------------
module rrip_ship_dip_replacement_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import rsd_pkg::*;

	// Rotate pacing every PACE_SPAN accepted requests
	localparam int PACE_SPAN = 120;

	typedef enum int {
		PACE_FREE,
		PACE_SENDER_IDLE,
		PACE_RECEIVER_STALL,
		PACE_BOTH
	} pace_t;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic             operation;
	logic [SET_W-1:0] set_index;
	logic [WAY_W-1:0] way;
	logic [PC_W-1:0]  pc;
	logic             hit;
	logic             out_valid;
	logic             out_stall;
	logic [WAY_W-1:0] victim_way;

	// Predicted policy state
	logic [1:0]       rerefs    [NUM_SETS][NUM_WAYS];
	logic [1:0]       dead_ctrs [NUM_SETS][NUM_WAYS];
	logic [1:0]       sig_ctrs  [SIG_ENTRIES];
	logic [SEL_W-1:0] selector;

	// Victim ways still owed by the unit, oldest first
	logic [WAY_W-1:0] pending_victims[$];

	// Small pool of PCs so that signature counters get trained both ways
	logic [PC_W-1:0]  hot_pcs[8];

	int sender_idle_pct    = 0;
	int receiver_stall_pct = 0;
	int requests_accepted  = 0;
	int mismatch_count     = 0;

	rrip_ship_dip_replacement_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operation  (operation),
		.set_index  (set_index),
		.way        (way),
		.pc         (pc),
		.hit        (hit),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.victim_way (victim_way)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ------------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------------

	// Fold the PC down to a signature table index
	function automatic logic [SIG_W-1:0] pc_signature(input logic [PC_W-1:0] p);
		logic [PC_W-1:0] folded;
		folded = p ^ (p >> HASH_SH_A) ^ (p >> HASH_SH_B);
		return SIG_W'(folded % SIG_ENTRIES);
	endfunction

	// Age the set until its oldest line is distant, then pick the first distant
	// line with a clear dead counter, falling back to the first distant line.
	function automatic logic [WAY_W-1:0] age_and_pick(input logic [SET_W-1:0] s);
		logic [1:0] oldest;
		logic [1:0] lift;
		int         pick;
		oldest = RRPV_NEAR;
		for (int w = 0; w < NUM_WAYS; w++) begin
			if (rerefs[s][w] > oldest)
				oldest = rerefs[s][w];
		end
		lift = RRPV_DISTANT - oldest;
		for (int w = 0; w < NUM_WAYS; w++)
			rerefs[s][w] = rerefs[s][w] + lift;
		pick = -1;
		for (int w = 0; w < NUM_WAYS; w++) begin
			if (pick < 0 && rerefs[s][w] == RRPV_DISTANT && dead_ctrs[s][w] == CTR_ZERO)
				pick = w;
		end
		for (int w = 0; w < NUM_WAYS; w++) begin
			if (pick < 0 && rerefs[s][w] == RRPV_DISTANT)
				pick = w;
		end
		if (pick < 0)
			pick = 0;
		return WAY_W'(pick);
	endfunction

	// Promote on a hit; on a miss nudge the selector from leader sets, then
	// place the line by signature confidence and selector.
	function automatic void apply_access(input logic [SET_W-1:0] s, input logic [WAY_W-1:0] w,
		input logic [PC_W-1:0] p, input logic h);
		logic [SIG_W-1:0] sig;
		logic [1:0]       conf;
		sig = pc_signature(p);
		if (h) begin
			rerefs[s][w]    = RRPV_NEAR;
			dead_ctrs[s][w] = CTR_TOP;
			if (sig_ctrs[sig] != CTR_TOP)
				sig_ctrs[sig] = sig_ctrs[sig] + 2'd1;
			return;
		end
		if ((s % DUEL_PERIOD) < (DUEL_PERIOD / 2)) begin
			if (selector != SEL_TOP)
				selector = selector + SEL_W'(1);
		end else if (selector != SEL_ZERO) begin
			selector = selector - SEL_W'(1);
		end
		if (sig_ctrs[sig] != CTR_ZERO)
			sig_ctrs[sig] = sig_ctrs[sig] - 2'd1;
		conf = sig_ctrs[sig];
		if (conf == CTR_ZERO) begin
			rerefs[s][w]    = RRPV_DISTANT;
			dead_ctrs[s][w] = CTR_ZERO;
		end else if (conf == CTR_TOP || selector >= SEL_MID) begin
			rerefs[s][w]    = RRPV_NEAR;
			dead_ctrs[s][w] = CTR_TOP;
		end else begin
			rerefs[s][w]    = RRPV_DISTANT;
			dead_ctrs[s][w] = CTR_TOP;
		end
	endfunction

	function automatic logic [PC_W-1:0] random_pc();
		if ($urandom_range(99) < 75)
			return hot_pcs[$urandom_range(7)];
		return {$urandom, $urandom};
	endfunction

	// ------------------------------------------------------------------------
	// Request driver: enter and leave on a falling edge. Hold the payload
	// until the unit takes it, then predict at the accepting edge.
	// ------------------------------------------------------------------------
	task automatic send_request(input op_t op, input logic [SET_W-1:0] s,
		input logic [WAY_W-1:0] w, input logic [PC_W-1:0] p, input logic h,
		output logic [WAY_W-1:0] chosen);
		case (pace_t'((requests_accepted / PACE_SPAN) % 4))
			PACE_FREE: begin
				sender_idle_pct    = 0;
				receiver_stall_pct = 0;
			end
			PACE_SENDER_IDLE: begin
				sender_idle_pct    = 82;
				receiver_stall_pct = 0;
			end
			PACE_RECEIVER_STALL: begin
				sender_idle_pct    = 0;
				receiver_stall_pct = 82;
			end
			default: begin
				sender_idle_pct    = 11;
				receiver_stall_pct = 11;
			end
		endcase
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		set_index <= s;
		way       <= w;
		pc        <= p;
		hit       <= h;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		if (op == OP_VICTIM) begin
			chosen = age_and_pick(s);
			pending_victims.push_back(chosen);
		end else begin
			apply_access(s, w, p, h);
			chosen = '0;
		end
		requests_accepted++;
		@(negedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Result side: random back-pressure, and compare each taken result with
	// the oldest prediction.
	// ------------------------------------------------------------------------
	always @(negedge clk)
		out_stall <= ($urandom_range(99) < receiver_stall_pct);

	always @(posedge clk) begin : result_check
		logic [WAY_W-1:0] want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_victims.size() == 0) begin
				$display("%0t: victim_way expected none, got %0d", $time, victim_way);
				mismatch_count++;
			end else begin
				want = pending_victims.pop_front();
				if (victim_way !== want) begin
					$display("%0t: victim_way expected %0d, got %0d", $time, want, victim_way);
					mismatch_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Hand-picked requests on a fresh unit: set and way extremes, PC extremes,
	// both leader halves at their boundaries, counter saturation, the selector
	// on either side of its midpoint, and the dead-counter preference.
	task automatic test_directed_cases();
		logic [WAY_W-1:0] v;
		// fresh sets give way 0; operands that a query ignores are junk
		send_request(OP_VICTIM, '0, '1, '1, 1'b1, v);
		send_request(OP_VICTIM, SET_W'(NUM_SETS - 1), '0, '0, 1'b0, v);
		// train the signature of PC 0 up to its ceiling and one past it
		send_request(OP_UPDATE, '0, '0, '0, 1'b1, v);
		send_request(OP_UPDATE, '0, '1, '0, 1'b1, v);
		send_request(OP_UPDATE, '0, WAY_W'(1), '0, 1'b1, v);
		send_request(OP_VICTIM, '0, '0, '0, 1'b0, v);
		// lowest BIP leader, confident signature, selector above midpoint
		send_request(OP_UPDATE, '0, WAY_W'(2), '0, 1'b0, v);
		// highest LRU leader: all-ones PC drops to zero confidence, then stays
		send_request(OP_UPDATE, SET_W'(DUEL_PERIOD - 1), '0, '1, 1'b0, v);
		send_request(OP_UPDATE, SET_W'(DUEL_PERIOD - 1), WAY_W'(1), '1, 1'b0, v);
		// leader half boundaries
		send_request(OP_UPDATE, SET_W'(DUEL_PERIOD / 2 - 1), WAY_W'(3), '0, 1'b0, v);
		send_request(OP_UPDATE, SET_W'(DUEL_PERIOD / 2), WAY_W'(4), '0, 1'b0, v);
		// retrain PC 0, then a medium-confidence miss with the selector below
		// midpoint leaves way 0 distant but marked
		send_request(OP_UPDATE, SET_W'(NUM_SETS - 1), WAY_W'(5), '0, 1'b1, v);
		send_request(OP_UPDATE, SET_W'(NUM_SETS - 1), WAY_W'(6), '0, 1'b1, v);
		send_request(OP_UPDATE, SET_W'(NUM_SETS - 1), '0, '0, 1'b0, v);
		// the marked line is passed over for the next clear distant one
		send_request(OP_VICTIM, SET_W'(NUM_SETS - 1), '1, '1, 1'b1, v);
		send_request(OP_VICTIM, SET_W'(DUEL_PERIOD - 1), '0, '0, 1'b0, v);
	endtask

	// Promote every way of a set so that nothing is distant, then run
	// query-then-fill sequences that keep ageing and refilling it.
	task automatic test_set_aging();
		logic [SET_W-1:0] s;
		logic [WAY_W-1:0] order;
		logic [WAY_W-1:0] victim;
		logic [WAY_W-1:0] v;
		int               r;
		repeat (3) begin
			s     = SET_W'($urandom_range(NUM_SETS - 1));
			order = WAY_W'($urandom);
			for (int w = 0; w < NUM_WAYS; w++)
				send_request(OP_UPDATE, s, WAY_W'(w) ^ order, random_pc(), 1'b1, v);
			repeat (20) begin
				send_request(OP_VICTIM, s, WAY_W'($urandom), random_pc(), 1'($urandom), victim);
				r = $urandom_range(99);
				if (r < 55)
					send_request(OP_UPDATE, s, victim, random_pc(), 1'b0, v);
				else if (r < 85)
					send_request(OP_UPDATE, s, WAY_W'($urandom), random_pc(), 1'b1, v);
				else
					send_request(OP_UPDATE, s, WAY_W'($urandom), random_pc(), 1'b0, v);
			end
		end
	endtask

	// Drive misses into BIP leaders until the selector has sat at its ceiling
	// for a while, then into LRU leaders until it sits at zero.
	task automatic test_selector_saturation();
		logic [SET_W-1:0] s;
		logic [WAY_W-1:0] v;
		int               r;
		int               pinned;
		for (int fall = 0; fall < 2; fall++) begin
			pinned = 0;
			while (pinned < 24) begin
				s = SET_W'($urandom_range(NUM_SETS - 1));
				// top bit of the slot picks the leader half
				s[DUEL_W-1] = (fall != 0);
				r = $urandom_range(99);
				if (r < 8) begin
					send_request(OP_VICTIM, s, WAY_W'($urandom), random_pc(), 1'($urandom), v);
				end else if (r < 14) begin
					send_request(OP_UPDATE, s, WAY_W'($urandom), random_pc(), 1'b1, v);
				end else begin
					send_request(OP_UPDATE, s, WAY_W'($urandom), random_pc(), 1'b0, v);
					if (selector == ((fall != 0) ? SEL_ZERO : SEL_TOP))
						pinned++;
				end
			end
		end
	endtask

	// Cache-like traffic on a handful of sets: fills after victim queries,
	// hits, lone queries, and some fully random requests as noise.
	task automatic test_mixed_traffic();
		logic [SET_W-1:0] busy_sets[6];
		logic [SET_W-1:0] s;
		logic [WAY_W-1:0] victim;
		logic [WAY_W-1:0] v;
		int               r;
		foreach (busy_sets[i])
			busy_sets[i] = SET_W'($urandom_range(NUM_SETS - 1));
		repeat (200) begin
			s = busy_sets[$urandom_range(5)];
			r = $urandom_range(99);
			if (r < 40) begin
				send_request(OP_VICTIM, s, WAY_W'($urandom), random_pc(), 1'($urandom), victim);
				send_request(OP_UPDATE, s, victim, random_pc(), 1'b0, v);
			end else if (r < 75) begin
				send_request(OP_UPDATE, s, WAY_W'($urandom), random_pc(), 1'b1, v);
			end else if (r < 88) begin
				send_request(OP_VICTIM, s, WAY_W'($urandom), random_pc(), 1'($urandom), v);
			end else begin
				send_request(op_t'($urandom_range(1)), SET_W'($urandom), WAY_W'($urandom),
					{$urandom, $urandom}, 1'($urandom), v);
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		operation = OP_VICTIM;
		set_index = '0;
		way       = '0;
		pc        = '0;
		hit       = 1'b0;
		out_stall = 1'b0;

		// initialise the predicted state to its reset values
		foreach (rerefs[s, w]) begin
			rerefs[s][w]    = RRPV_DISTANT;
			dead_ctrs[s][w] = CTR_ZERO;
		end
		foreach (sig_ctrs[i])
			sig_ctrs[i] = SIG_RESET;
		selector = SEL_MID;
		foreach (hot_pcs[i])
			hot_pcs[i] = {$urandom, $urandom};

		// hold reset, then release it on a falling edge; the clearing pass shows up as in_stall
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_cases();
		test_set_aging();
		test_selector_saturation();
		test_mixed_traffic();

		// drop valid, release back-pressure and drain what is owed
		in_valid <= 1'b0;
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		while (pending_victims.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run, clearing pass included
	initial begin
		#5ms;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

### files.f
design/rsd_pkg.sv
design/rsd_victim_pick.sv
design/rrip_ship_dip_replacement_unit.sv
verif/rrip_ship_dip_replacement_unit_test.sv
